@@ rtl/frequency_sensor_cubic_rate_macros.svh @@
// Assertion helpers shared by the RTL files. Clock and reset names are the
// project's standard ones.
`ifndef FREQUENCY_SENSOR_CUBIC_RATE_MACROS_SVH
`define FREQUENCY_SENSOR_CUBIC_RATE_MACROS_SVH
`ifndef SYNTHESIS
`define FSCR_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
`define FSCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FSCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FSCR_ASSERT(lbl, cond)
`define FSCR_ASSERT_IMP(lbl, ante, cons)
`define FSCR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/fscr_pkg.sv @@
package fscr_pkg;

  localparam int unsigned CAPTURE_HZ = 1000000;
  localparam int unsigned DIV_W = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
  localparam logic [63:0] FREQ_DIVIDEND = 64'(CAPTURE_HZ) << 16;
  localparam logic [79:0] TERM_CAP = 80'd1 << 60;

  typedef enum logic [2:0] {
    CFG_COEF_ZERO  = 3'd0,
    CFG_COEF_ONE   = 3'd1,
    CFG_COEF_TWO   = 3'd2,
    CFG_COEF_THREE = 3'd3,
    CFG_MIN_VALUE  = 3'd4,
    CFG_MAX_VALUE  = 3'd5,
    CFG_DERIV_RATE = 3'd6,
    CFG_TICKS_SEC  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_FREQ,
    ST_MUL_FF,
    ST_MUL_P2F,
    ST_MUL_C1,
    ST_MUL_C2,
    ST_MUL_C3,
    ST_CLAMP,
    ST_DIV_THR,
    ST_CHECK,
    ST_MUL_RATE,
    ST_DIV_RATE,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    MSEL_FF,
    MSEL_P2F,
    MSEL_C1,
    MSEL_C2,
    MSEL_C3,
    MSEL_RATE
  } mul_sel_e;

  typedef enum logic [1:0] {
    DSEL_FREQ,
    DSEL_THR,
    DSEL_RATE
  } div_sel_e;

  typedef enum logic [1:0] {
    MPH_IDLE,
    MPH_LO,
    MPH_HI,
    MPH_SUM
  } mul_ph_e;

  typedef struct packed {
    logic     load;
    logic     commit;
    logic     clamp;
    logic     set_vupd;
    logic     set_rupd;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic period_zero;
    logic tick_changed;
    logic elapsed_ok;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/fscr_div.sv @@
module fscr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fscr_pkg::DIV_W-1:0] dividend_i,
  input  logic [31:0]               divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [fscr_pkg::DIV_W-1:0] quotient_o
);

  logic [fscr_pkg::DIV_W-1:0]     quo_q;
  logic [31:0]                    rem_q;
  logic [31:0]                    dvs_q;
  logic [fscr_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [32:0]                    shifted;
  logic                           ge;
  logic [32:0]                    diff;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    shifted = {rem_q, quo_q[fscr_pkg::DIV_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == fscr_pkg::DIV_CNT_W'(fscr_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : shifted[31:0];
      quo_q <= {quo_q[fscr_pkg::DIV_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/fscr_datapath.sv @@
`include "frequency_sensor_cubic_rate_macros.svh"

module fscr_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [63:0]    s_tdata_i,
  input  logic           cfg_valid_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  input  fscr_pkg::cmd_t cmd_i,
  output fscr_pkg::sts_t sts_o,
  input  logic           m_tready_i,
  output logic           m_tvalid_o,
  output logic [63:0]    m_tdata_o,
  output logic [1:0]     m_tuser_o
);

  function automatic logic [31:0] mag32(input logic [31:0] c);
    mag32 = c[31] ? (~c + 32'd1) : c;
  endfunction

  // Configuration
  logic [31:0] coef0_q, coef1_q, coef2_q, coef3_q, min_q, max_q, tps_q;
  logic [15:0] drate_q;

  // Item state
  logic [31:0] period_q, now_q, f_q, thr_q, val_q, rate_q;
  logic [63:0] p2_q, p3_q, rprod_q;
  logic signed [63:0] sum_q;
  logic        vupd_q, rupd_q;

  // Held state and output
  logic [31:0] held_value_q, held_rate_q, last_val_q, last_tick_q;
  logic        out_valid_q, out_vupd_q, out_rupd_q;

  // Shared multiplier
  fscr_pkg::mul_ph_e  mul_ph_q;
  fscr_pkg::mul_sel_e mul_sel_q;
  logic [31:0] mul_a_q;
  logic [63:0] mul_b_q;
  logic        mul_neg_q;
  logic [63:0] pp_lo_q, pp_hi_q;
  logic [31:0] mul_a, mul_part;
  logic [63:0] mul_b, prod;
  logic        mul_neg;
  logic [95:0] acc;
  logic [79:0] shr;
  logic [63:0] mres;
  logic signed [63:0] term;

  // Divider
  fscr_pkg::div_sel_e div_sel_q;
  logic [63:0] div_dividend, div_quo;
  logic [31:0] div_divisor, elapsed;
  logic        div_busy, div_done;

  // Value and rate shaping
  logic signed [31:0] sat_val, clamp_val;
  logic [32:0] diff;
  logic        diff_neg;
  logic [31:0] diff_mag;

  always_comb begin
    elapsed  = now_q - last_tick_q;
    diff     = {val_q[31], val_q} - {last_val_q[31], last_val_q};
    diff_neg = diff[32];
    diff_mag = diff_neg ? (~diff[31:0] + 32'd1) : diff[31:0];
  end

  always_comb begin
    mul_a   = f_q;
    mul_b   = {32'd0, f_q};
    mul_neg = 1'b0;
    case (cmd_i.mul_sel)
      fscr_pkg::MSEL_FF: begin
        mul_a = f_q;
        mul_b = {32'd0, f_q};
      end
      fscr_pkg::MSEL_P2F: begin
        mul_a = f_q;
        mul_b = p2_q;
      end
      fscr_pkg::MSEL_C1: begin
        mul_a   = mag32(coef1_q);
        mul_b   = {32'd0, f_q};
        mul_neg = coef1_q[31];
      end
      fscr_pkg::MSEL_C2: begin
        mul_a   = mag32(coef2_q);
        mul_b   = p2_q;
        mul_neg = coef2_q[31];
      end
      fscr_pkg::MSEL_C3: begin
        mul_a   = mag32(coef3_q);
        mul_b   = p3_q;
        mul_neg = coef3_q[31];
      end
      fscr_pkg::MSEL_RATE: begin
        mul_a = diff_mag;
        mul_b = {32'd0, tps_q};
      end
      default: begin
        mul_a = f_q;
      end
    endcase
  end

  always_comb begin
    mul_part = (mul_ph_q == fscr_pkg::MPH_LO) ? mul_b_q[31:0] : mul_b_q[63:32];
    prod     = mul_a_q * mul_part;
    acc      = {32'd0, pp_lo_q} + {pp_hi_q, 32'd0};
    shr      = acc[95:16];
    mres     = (shr > fscr_pkg::TERM_CAP) ? fscr_pkg::TERM_CAP[63:0] : shr[63:0];
    term     = mul_neg_q ? -$signed(mres) : $signed(mres);
  end

  always_comb begin
    if (sum_q > 64'sd2147483647) begin
      sat_val = 32'sh7FFFFFFF;
    end else if (sum_q < -64'sd2147483648) begin
      sat_val = 32'sh80000000;
    end else begin
      sat_val = sum_q[31:0];
    end
    if (sat_val < $signed(min_q)) begin
      clamp_val = $signed(min_q);
    end else if (sat_val > $signed(max_q)) begin
      clamp_val = $signed(max_q);
    end else begin
      clamp_val = sat_val;
    end
  end

  always_comb begin
    div_dividend = fscr_pkg::FREQ_DIVIDEND;
    div_divisor  = period_q;
    case (cmd_i.div_sel)
      fscr_pkg::DSEL_FREQ: begin
        div_dividend = fscr_pkg::FREQ_DIVIDEND;
        div_divisor  = period_q;
      end
      fscr_pkg::DSEL_THR: begin
        div_dividend = {32'd0, tps_q};
        div_divisor  = (drate_q == 16'd0) ? 32'd1 : {16'd0, drate_q};
      end
      fscr_pkg::DSEL_RATE: begin
        div_dividend = rprod_q;
        div_divisor  = elapsed;
      end
      default: begin
        div_divisor = period_q;
      end
    endcase
  end

  fscr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef0_q <= '0;
      coef1_q <= '0;
      coef2_q <= '0;
      coef3_q <= '0;
      min_q   <= 32'h80000000;
      max_q   <= 32'h7FFFFFFF;
      drate_q <= 16'd1;
      tps_q   <= 32'd1000000;
    end else if (cfg_valid_i) begin
      case (fscr_pkg::cfg_idx_e'(cfg_index_i))
        fscr_pkg::CFG_COEF_ZERO:  coef0_q <= cfg_data_i;
        fscr_pkg::CFG_COEF_ONE:   coef1_q <= cfg_data_i;
        fscr_pkg::CFG_COEF_TWO:   coef2_q <= cfg_data_i;
        fscr_pkg::CFG_COEF_THREE: coef3_q <= cfg_data_i;
        fscr_pkg::CFG_MIN_VALUE:  min_q   <= cfg_data_i;
        fscr_pkg::CFG_MAX_VALUE:  max_q   <= cfg_data_i;
        fscr_pkg::CFG_DERIV_RATE: drate_q <= cfg_data_i[15:0];
        fscr_pkg::CFG_TICKS_SEC:  tps_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_ph_q     <= fscr_pkg::MPH_IDLE;
      held_value_q <= '0;
      held_rate_q  <= '0;
      last_val_q   <= '0;
      last_tick_q  <= '0;
      out_valid_q  <= 1'b0;
      out_vupd_q   <= 1'b0;
      out_rupd_q   <= 1'b0;
      vupd_q       <= 1'b0;
      rupd_q       <= 1'b0;
    end else begin
      case (mul_ph_q)
        fscr_pkg::MPH_IDLE: if (cmd_i.mul_start) mul_ph_q <= fscr_pkg::MPH_LO;
        fscr_pkg::MPH_LO:   mul_ph_q <= fscr_pkg::MPH_HI;
        fscr_pkg::MPH_HI:   mul_ph_q <= fscr_pkg::MPH_SUM;
        default:            mul_ph_q <= fscr_pkg::MPH_IDLE;
      endcase
      if (cmd_i.load) begin
        vupd_q <= 1'b0;
        rupd_q <= 1'b0;
      end else begin
        if (cmd_i.set_vupd) vupd_q <= 1'b1;
        if (cmd_i.set_rupd) rupd_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        out_vupd_q  <= vupd_q;
        out_rupd_q  <= rupd_q;
        if (vupd_q) held_value_q <= val_q;
        if (rupd_q) begin
          held_rate_q <= rate_q;
          last_tick_q <= now_q;
          last_val_q  <= val_q;
        end
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      period_q <= s_tdata_i[31:0];
      now_q    <= s_tdata_i[63:32];
      sum_q    <= 64'($signed(coef0_q));
    end
    if (cmd_i.mul_start) begin
      mul_a_q   <= mul_a;
      mul_b_q   <= mul_b;
      mul_neg_q <= mul_neg;
      mul_sel_q <= cmd_i.mul_sel;
    end
    if (mul_ph_q == fscr_pkg::MPH_LO) pp_lo_q <= prod;
    if (mul_ph_q == fscr_pkg::MPH_HI) pp_hi_q <= prod;
    if (mul_ph_q == fscr_pkg::MPH_SUM) begin
      case (mul_sel_q)
        fscr_pkg::MSEL_FF:   p2_q    <= mres;
        fscr_pkg::MSEL_P2F:  p3_q    <= mres;
        fscr_pkg::MSEL_RATE: rprod_q <= acc[63:0];
        default:             sum_q   <= sum_q + term;
      endcase
    end
    if (cmd_i.div_start) div_sel_q <= cmd_i.div_sel;
    if (div_done) begin
      case (div_sel_q)
        fscr_pkg::DSEL_FREQ:
          f_q <= (div_quo[63:32] != 32'd0) ? 32'hFFFFFFFF : div_quo[31:0];
        fscr_pkg::DSEL_THR:
          thr_q <= div_quo[31:0];
        default: begin
          if (diff_neg) begin
            rate_q <= (div_quo > 64'h80000000) ? 32'h80000000
                                               : (~div_quo[31:0] + 32'd1);
          end else begin
            rate_q <= (div_quo > 64'h7FFFFFFF) ? 32'h7FFFFFFF : div_quo[31:0];
          end
        end
      endcase
    end
    if (cmd_i.clamp) val_q <= clamp_val;
  end

  always_comb begin
    sts_o.div_done     = div_done;
    sts_o.mul_done     = (mul_ph_q == fscr_pkg::MPH_SUM);
    sts_o.period_zero  = (s_tdata_i[31:0] == 32'd0);
    sts_o.tick_changed = (now_q != last_tick_q);
    sts_o.elapsed_ok   = (elapsed >= thr_q);
    sts_o.out_free     = !out_valid_q || m_tready_i;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {held_rate_q, held_value_q};
  assign m_tuser_o  = {out_rupd_q, out_vupd_q};

  `FSCR_ASSERT_IMP(a_div_start_idle, cmd_i.div_start, !div_busy)
  `FSCR_ASSERT_IMP(a_mul_start_idle, cmd_i.mul_start, mul_ph_q == fscr_pkg::MPH_IDLE)
  `FSCR_ASSERT_NEXT(a_commit_shows, cmd_i.commit, m_tvalid_o)

endmodule

@@ rtl/fscr_ctrl.sv @@
`include "frequency_sensor_cubic_rate_macros.svh"

module fscr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fscr_pkg::sts_t sts_i,
  output fscr_pkg::cmd_t cmd_o
);

  fscr_pkg::state_e state_q, state_d;
  logic             issued_q, issued_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fscr_pkg::ST_IDLE:
        if (in_valid_i) state_d = sts_i.period_zero ? fscr_pkg::ST_FINISH
                                                    : fscr_pkg::ST_DIV_FREQ;
      fscr_pkg::ST_DIV_FREQ: if (sts_i.div_done) state_d = fscr_pkg::ST_MUL_FF;
      fscr_pkg::ST_MUL_FF:   if (sts_i.mul_done) state_d = fscr_pkg::ST_MUL_P2F;
      fscr_pkg::ST_MUL_P2F:  if (sts_i.mul_done) state_d = fscr_pkg::ST_MUL_C1;
      fscr_pkg::ST_MUL_C1:   if (sts_i.mul_done) state_d = fscr_pkg::ST_MUL_C2;
      fscr_pkg::ST_MUL_C2:   if (sts_i.mul_done) state_d = fscr_pkg::ST_MUL_C3;
      fscr_pkg::ST_MUL_C3:   if (sts_i.mul_done) state_d = fscr_pkg::ST_CLAMP;
      fscr_pkg::ST_CLAMP:
        state_d = sts_i.tick_changed ? fscr_pkg::ST_DIV_THR : fscr_pkg::ST_FINISH;
      fscr_pkg::ST_DIV_THR:  if (sts_i.div_done) state_d = fscr_pkg::ST_CHECK;
      fscr_pkg::ST_CHECK:
        state_d = sts_i.elapsed_ok ? fscr_pkg::ST_MUL_RATE : fscr_pkg::ST_FINISH;
      fscr_pkg::ST_MUL_RATE: if (sts_i.mul_done) state_d = fscr_pkg::ST_DIV_RATE;
      fscr_pkg::ST_DIV_RATE: if (sts_i.div_done) state_d = fscr_pkg::ST_FINISH;
      fscr_pkg::ST_FINISH:   if (sts_i.out_free) state_d = fscr_pkg::ST_IDLE;
      default:               state_d = fscr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      fscr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      fscr_pkg::ST_DIV_FREQ: begin
        cmd_o.div_start = !issued_q;
        cmd_o.div_sel   = fscr_pkg::DSEL_FREQ;
      end
      fscr_pkg::ST_MUL_FF: begin
        cmd_o.mul_start = !issued_q;
        cmd_o.mul_sel   = fscr_pkg::MSEL_FF;
      end
      fscr_pkg::ST_MUL_P2F: begin
        cmd_o.mul_start = !issued_q;
        cmd_o.mul_sel   = fscr_pkg::MSEL_P2F;
      end
      fscr_pkg::ST_MUL_C1: begin
        cmd_o.mul_start = !issued_q;
        cmd_o.mul_sel   = fscr_pkg::MSEL_C1;
      end
      fscr_pkg::ST_MUL_C2: begin
        cmd_o.mul_start = !issued_q;
        cmd_o.mul_sel   = fscr_pkg::MSEL_C2;
      end
      fscr_pkg::ST_MUL_C3: begin
        cmd_o.mul_start = !issued_q;
        cmd_o.mul_sel   = fscr_pkg::MSEL_C3;
      end
      fscr_pkg::ST_CLAMP: begin
        cmd_o.clamp    = 1'b1;
        cmd_o.set_vupd = 1'b1;
      end
      fscr_pkg::ST_DIV_THR: begin
        cmd_o.div_start = !issued_q;
        cmd_o.div_sel   = fscr_pkg::DSEL_THR;
      end
      fscr_pkg::ST_CHECK: begin
        cmd_o.set_rupd = sts_i.elapsed_ok;
      end
      fscr_pkg::ST_MUL_RATE: begin
        cmd_o.mul_start = !issued_q;
        cmd_o.mul_sel   = fscr_pkg::MSEL_RATE;
      end
      fscr_pkg::ST_DIV_RATE: begin
        cmd_o.div_start = !issued_q;
        cmd_o.div_sel   = fscr_pkg::DSEL_RATE;
      end
      fscr_pkg::ST_FINISH: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: ;
    endcase
  end

  // Each compute state launches its unit once, then waits for the done strobe.
  assign issued_d = (state_d == state_q) &&
                    (issued_q || cmd_o.mul_start || cmd_o.div_start);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fscr_pkg::ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  `FSCR_ASSERT(a_one_unit, !(cmd_o.mul_start && cmd_o.div_start))
  `FSCR_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o)
  `FSCR_ASSERT_IMP(a_div_done_in_div, sts_i.div_done,
                   state_q == fscr_pkg::ST_DIV_FREQ || state_q == fscr_pkg::ST_DIV_THR ||
                   state_q == fscr_pkg::ST_DIV_RATE)

endmodule

@@ rtl/frequency_sensor_cubic_rate.sv @@
// A zero period goes straight to the result; otherwise the value is computed, and when the
// tick has changed the rate threshold is checked, with a rate update once it is reached.
// The next input is taken while the result register waits, and a stalled result holds
// the following item in its last state. Divisions run on the bit-serial divider,
// multiplications on a 32x32 unit.
// Reset (rst_ni low, asynchronous) clears held value, rate and rate reference.
module frequency_sensor_cubic_rate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // period_ticks[31:0], now_tick[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // sensor_value[31:0], sensor_rate[63:32]
  output logic [1:0]  m_axis_tuser,  // value_updated[0], rate_updated[1]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  fscr_pkg::cmd_t cmd;
  fscr_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  fscr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fscr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

@@ tb/sv/frequency_sensor_cubic_rate_tb.sv @@
`timescale 1ns / 1ps

module frequency_sensor_cubic_rate_tb;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] rate;
    logic        vupd;
    logic        rupd;
  } reading_t;

  localparam logic [127:0] PRODUCT_CAP = 128'd1 << 60;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned WATCHDOG_LIMIT = 6000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  frequency_sensor_cubic_rate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Calibration and rate state as seen by the predictor.
  logic [31:0] c_zero, c_one, c_two, c_three, lo_clamp, hi_clamp, tick_rate;
  logic [15:0] deriv_rate;
  logic [31:0] hold_val, hold_rate, ref_val, ref_tick;

  logic [63:0] sample_q[$];
  reading_t    reading_q[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en = 1'b1;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_off = 0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> 16;
    return (p > PRODUCT_CAP) ? PRODUCT_CAP[63:0] : p[63:0];
  endfunction

  function automatic logic signed [63:0] poly_term(input logic [31:0] coef,
                                                   input logic [63:0] pw);
    logic signed [63:0] c;
    logic [63:0]        mag;
    c = {{32{coef[31]}}, coef};
    mag = c[63] ? -c : c;
    mag = qmul(mag, pw);
    return c[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic reading_t calibrate_reading(input logic [63:0] sample);
    logic [31:0]        period, now, elapsed, thr;
    logic [63:0]        f, p2, p3, mag;
    logic signed [63:0] acc, diff, lo, hi;
    logic [127:0]       q;
    reading_t           r;
    period = sample[31:0];
    now = sample[63:32];
    r.vupd = 1'b0;
    r.rupd = 1'b0;
    if (period != 0) begin
      f = (64'd1000000 << 16) / period;
      if (f > 64'hFFFF_FFFF) f = 64'hFFFF_FFFF;
      p2 = qmul(f, f);
      p3 = qmul(p2, f);
      acc = $signed({{32{c_zero[31]}}, c_zero}) + poly_term(c_one, f)
          + poly_term(c_two, p2) + poly_term(c_three, p3);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      lo = {{32{lo_clamp[31]}}, lo_clamp};
      hi = {{32{hi_clamp[31]}}, hi_clamp};
      // A value below the lower bound wins even when the bounds are crossed.
      if (acc < lo) acc = lo;
      else if (acc > hi) acc = hi;
      hold_val = acc[31:0];
      r.vupd = 1'b1;
      if (now != ref_tick) begin
        elapsed = now - ref_tick;
        thr = tick_rate / ((deriv_rate == 0) ? 32'd1 : {16'd0, deriv_rate});
        if (elapsed >= thr) begin
          diff = acc - $signed({{32{ref_val[31]}}, ref_val});
          mag = diff[63] ? -diff : diff;
          q = ({64'd0, mag} * {96'd0, tick_rate}) / {96'd0, elapsed};
          if (diff[63])
            hold_rate = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
          else
            hold_rate = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
          ref_tick = now;
          ref_val = hold_val;
          r.rupd = 1'b1;
        end
      end
    end
    r.value = hold_val;
    r.rate = hold_rate;
    return r;
  endfunction

  // Sender: one transfer per handshake, with random bursts of idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) reading_q.push_back(calibrate_reading(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          s_axis_tdata <= sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
          if (idle_en && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 11);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each result transfer against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap <= 0;
      hold_off <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (reading_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("Unexpected result %h user %b", m_axis_tdata, m_axis_tuser);
        end else begin
          exp_r = reading_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_r.value || m_axis_tdata[63:32] !== exp_r.rate ||
              m_axis_tuser[0] !== exp_r.vupd || m_axis_tuser[1] !== exp_r.rupd) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("Mismatch: value %h/%h rate %h/%h vupd %b/%b rupd %b/%b (exp/act)",
                       exp_r.value, m_axis_tdata[31:0], exp_r.rate, m_axis_tdata[63:32],
                       exp_r.vupd, m_axis_tuser[0], exp_r.rupd, m_axis_tuser[1]);
          end
        end
      end
      if (results_seen == 300 && m_axis_tvalid && m_axis_tready) begin
        // Long hold-off so the block backs up and stalls its input.
        hold_off <= 400;
        m_axis_tready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input fscr_pkg::cfg_idx_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      fscr_pkg::CFG_COEF_ZERO:  c_zero = data;
      fscr_pkg::CFG_COEF_ONE:   c_one = data;
      fscr_pkg::CFG_COEF_TWO:   c_two = data;
      fscr_pkg::CFG_COEF_THREE: c_three = data;
      fscr_pkg::CFG_MIN_VALUE:  lo_clamp = data;
      fscr_pkg::CFG_MAX_VALUE:  hi_clamp = data;
      fscr_pkg::CFG_DERIV_RATE: deriv_rate = data[15:0];
      fscr_pkg::CFG_TICKS_SEC:  tick_rate = data;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rnd_coef();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: return $urandom_range(0, 512) - 256;
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic setup_phase(input int ph);
    logic [31:0] v[8];
    logic [31:0] a, b;
    case (ph)
      0: v = '{32'h0000_0001, 32'h0001_0000, 32'h0, 32'h0,
               32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1000000};
      1: v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'd65535, 32'hFFFF_FFFF};
      2: begin
        // Crossed bounds, zero derivative rate and zero ticks per second.
        a = $urandom_range(1000, 100000);
        v = '{rnd_coef(), rnd_coef(), rnd_coef(), 32'h0,
              a, a - 32'd500, 32'd0, 32'd0};
      end
      default: begin
        a = $urandom();
        b = $urandom();
        if ($signed(a) > $signed(b)) {a, b} = {b, a};
        if ($urandom_range(0, 1)) begin
          a = 32'h8000_0000;
          b = 32'h7FFF_FFFF;
        end
        v = '{rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef(), a, b,
              ($urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 50)),
              ($urandom_range(0, 1) ? $urandom() : $urandom_range(1, 2000000))};
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(fscr_pkg::cfg_idx_e'(i), v[i]);
  endtask

  task automatic wait_drained();
    while (sample_q.size() > 0 || reading_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] tick, period, thr;
    logic [31:0] step;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    c_zero = 0; c_one = 0; c_two = 0; c_three = 0;
    lo_clamp = 32'h8000_0000; hi_clamp = 32'h7FFF_FFFF;
    deriv_rate = 16'd1; tick_rate = 32'd1000000;
    hold_val = 0; hold_rate = 0; ref_val = 0; ref_tick = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tick = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_en = (ph != NUM_PHASES - 1);
      setup_phase(ph);
      if (ph == 0) begin
        // Tick unchanged, zero period, period extremes and tick wrap.
        sample_q.push_back({32'd0, 32'd1000});
        sample_q.push_back({32'd0, 32'd0});
        sample_q.push_back({32'd1000000, 32'd1});
        sample_q.push_back({32'd1000001, 32'd2});
        sample_q.push_back({32'd3000000, 32'hFFFF_FFFF});
        sample_q.push_back({32'd3000000, 32'd0});
        sample_q.push_back({32'hFFFF_FFFF, 32'd65536});
        sample_q.push_back({32'd1000000, 32'd1000000});
        sample_q.push_back({32'd500, 32'd100});
        sample_q.push_back({32'hFFFF_FFFF, 32'd0});
        tick = 32'd1000000;
      end
      if (ph == 1) begin
        // Saturating terms with the extreme coefficients.
        sample_q.push_back({32'd5, 32'd1});
        sample_q.push_back({32'd10, 32'd2});
        sample_q.push_back({32'hFFFF_FFFF, 32'd1});
        sample_q.push_back({32'd7, 32'hFFFF_FFFF});
      end
      for (int n = 0; n < 235; n++) begin
        thr = tick_rate / ((deriv_rate == 0) ? 32'd1 : {16'd0, deriv_rate});
        case ($urandom_range(0, 7))
          0: step = 0;
          1: step = $urandom();
          2, 3: step = $urandom_range(0, thr[31] ? 32'hFFFF_FFFF : {thr[30:0], 1'b1});
          default: step = $urandom_range(1, 3000);
        endcase
        tick = tick + step;
        case ($urandom_range(0, 15))
          0: period = 0;
          1: period = $urandom();
          2: period = $urandom_range(1, 16);
          default: period = $urandom_range(1000, 2000000);
        endcase
        sample_q.push_back({tick, period});
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
